// File: design/ps2s_pkg.sv
package ps2s_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES     = 3'd6;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_GAP   = 2'd1;
    localparam logic [1:0] KIND_AXIS  = 2'd2;
    localparam logic [1:0] KIND_LEVEL = 2'd3;

    typedef struct packed {
        logic [9:0]         pos_x;
        logic [9:0]         pos_y;
        logic [9:0]         plot_width;
        logic [9:0]         plot_height;
        logic signed [31:0] y_min;
        logic [31:0]        y_scale;
        logic [15:0]        samples;
    } cfg_t;

    typedef struct packed {
        logic               link;
        logic               link_gap;
        logic               last;
        logic               plot;
        logic               smp_valid;
        logic signed [15:0] x;
    } item_t;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: design/ps2s_ctrl.sv
module ps2s_ctrl #(
    parameter int COUNT_BITS = ps2s_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ps2s_pkg::cfg_t      cfg,
    input  logic                cfg_wr_en,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_value,
    input  logic                s_flag,
    input  logic                adv,
    output logic                s1_vld,
    output ps2s_pkg::item_t     s1_item,
    output logic signed [31:0]  s1_raw
);
    import ps2s_pkg::*;

    localparam int CW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int STEP_W = $clog2(CW + 1);

    typedef enum logic [1:0] {DIV_IDLE, DIV_LOAD, DIV_RUN} div_state_t;

    div_state_t              state_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic                    pv_reg;
    logic                    gp_reg;
    logic [CW-1:0]           q_reg;
    logic [9:0]              r_reg;
    logic [CW-1:0]           dvd_reg;
    logic [9:0]              rem_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    s1_vld_reg;
    item_t                   s1_item_reg;
    logic signed [31:0]      s1_raw_reg;

    logic [15:0]             n16;
    logic [15:0]             start16;
    logic [CW-1:0]           cnt_ext;
    logic [CW-1:0]           start_ext;
    logic [CW-1:0]           k;
    logic                    in_win;
    logic                    last;
    logic                    wide;
    logic [CW:0]             off;
    logic [CW+1:0]           xsum;
    logic signed [15:0]      x;
    logic                    accept;
    logic [COUNT_BITS-1:0]   cnt_next;
    logic                    pv_next;
    logic                    gp_next;
    logic [9:0]              dsr;
    logic [10:0]             r_inc;
    logic [10:0]             rem_sh;
    logic                    ge;
    logic [10:0]             rem_sub;
    logic [CW-1:0]           dvd_next;

    always_comb begin
        n16       = (cfg.samples == 16'd0) ? 16'd1 : cfg.samples;
        start16   = (n16 > {6'd0, cfg.plot_width}) ? n16 - {6'd0, cfg.plot_width} : 16'd0;
        cnt_ext   = CW'(cnt_reg);
        start_ext = CW'(start16);
        k         = cnt_ext - start_ext;
        in_win    = (cfg.plot_width != 10'd0) && (cnt_ext >= start_ext);
        last      = cnt_ext >= CW'(n16 - 16'd1);
        wide      = cfg.plot_width >= 10'd2;
        off       = wide ? ({1'b0, k} + {1'b0, q_reg}) : '0;
        xsum      = {1'b0, off} + (CW+2)'(cfg.pos_x);
        x         = (xsum > (CW+2)'(32767)) ? 16'sh7fff : xsum[15:0];
        accept    = s_valid && s_ready;
        cnt_next  = last ? '0 : cnt_reg + 1'b1;
        dsr       = wide ? cfg.plot_width - 10'd1 : 10'd1;
        r_inc     = {1'b0, r_reg} + 11'd1;
        rem_sh    = {rem_reg, dvd_reg[CW-1]};
        ge        = rem_sh >= {1'b0, dsr};
        rem_sub   = rem_sh - {1'b0, dsr};
        dvd_next  = {dvd_reg[CW-2:0], ge};

        pv_next = pv_reg;
        gp_next = gp_reg;
        if (in_win) begin
            if (s_flag) begin
                pv_next = 1'b1;
                gp_next = 1'b0;
            end else begin
                if (pv_reg) begin
                    gp_next = 1'b1;
                end
                pv_next = 1'b0;
            end
        end
        if (last) begin
            pv_next = 1'b0;
            gp_next = 1'b0;
        end
    end

    assign s_ready = adv && (state_reg == DIV_IDLE);
    assign s1_vld  = s1_vld_reg;
    assign s1_item = s1_item_reg;
    assign s1_raw  = s1_raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= DIV_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            gp_reg     <= 1'b0;
            q_reg      <= '0;
            r_reg      <= '0;
            step_reg   <= '0;
            s1_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_vld_reg <= accept;
            end
            if (accept) begin
                s1_raw_reg            <= s_value;
                s1_item_reg.link      <= in_win && s_flag && (pv_reg || gp_reg);
                s1_item_reg.link_gap  <= !pv_reg;
                s1_item_reg.last      <= last;
                s1_item_reg.plot      <= in_win && s_flag;
                s1_item_reg.smp_valid <= s_flag;
                s1_item_reg.x         <= x;
                cnt_reg <= cnt_next;
                pv_reg  <= pv_next;
                gp_reg  <= gp_next;
                // track window index / (width - 1) incrementally
                if (CW'(cnt_next) == start_ext) begin
                    q_reg <= '0;
                    r_reg <= '0;
                end else if (in_win) begin
                    if (r_inc == {1'b0, dsr}) begin
                        r_reg <= '0;
                        q_reg <= q_reg + 1'b1;
                    end else begin
                        r_reg <= r_inc[9:0];
                    end
                end
            end
            // restart the window index recompute on any register write
            if (cfg_wr_en) begin
                state_reg <= DIV_LOAD;
            end else begin
                unique case (state_reg)
                    DIV_IDLE: begin
                    end
                    DIV_LOAD: begin
                        dvd_reg   <= k;
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(CW);
                        state_reg <= DIV_RUN;
                    end
                    DIV_RUN: begin
                        dvd_reg  <= dvd_next;
                        rem_reg  <= ge ? rem_sub[9:0] : rem_sh[9:0];
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == STEP_W'(1)) begin
                            q_reg     <= dvd_next;
                            r_reg     <= ge ? rem_sub[9:0] : rem_sh[9:0];
                            state_reg <= DIV_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= DIV_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// File: design/ps2s_ymap.sv
module ps2s_ymap (
    input  logic                aclk,
    input  logic                aresetn,
    input  ps2s_pkg::cfg_t      cfg,
    input  logic                adv,
    input  logic                s1_vld,
    input  ps2s_pkg::item_t     s1_item,
    input  logic signed [31:0]  s1_raw,
    output logic                s3_vld,
    output ps2s_pkg::item_t     s3_item,
    output logic [31:0]         s3_t,
    output logic                s3_neg
);
    import ps2s_pkg::*;

    logic               s2_vld_reg;
    item_t              s2_item_reg;
    logic [32:0]        s2_mag_reg;
    logic               s2_neg_reg;
    logic               s3_vld_reg;
    item_t              s3_item_reg;
    logic [31:0]        s3_t_reg;
    logic               s3_neg_reg;

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [64:0]        prod;

    always_comb begin
        diff = {s1_raw[31], s1_raw} - {cfg.y_min[31], cfg.y_min};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        prod = 65'(s2_mag_reg) * 65'(cfg.y_scale);
    end

    assign s3_vld  = s3_vld_reg;
    assign s3_item = s3_item_reg;
    assign s3_t    = s3_t_reg;
    assign s3_neg  = s3_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg  <= s1_vld;
            s2_item_reg <= s1_item;
            s2_mag_reg  <= mag;
            s2_neg_reg  <= diff[32];
            s3_vld_reg  <= s2_vld_reg;
            s3_item_reg <= s2_item_reg;
            s3_t_reg    <= prod[63:32];
            s3_neg_reg  <= s2_neg_reg;
        end
    end

endmodule

// File: design/ps2s_seg_out.sv
module ps2s_seg_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  ps2s_pkg::cfg_t      cfg,
    input  logic                s3_vld,
    input  ps2s_pkg::item_t     s3_item,
    input  logic [31:0]         s3_t,
    input  logic                s3_neg,
    output logic                adv,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_data,
    output logic [1:0]          m_kind,
    output logic                m_last
);
    import ps2s_pkg::*;

    // pending beats: link, bottom axis, top axis, level line
    logic [3:0]          mask_reg;
    logic [3:0]          mask_next;
    logic signed [15:0]  prev_x_reg;
    logic signed [15:0]  prev_y_reg;
    logic signed [15:0]  lx1_reg;
    logic signed [15:0]  ly1_reg;
    logic signed [15:0]  lx2_reg;
    logic signed [15:0]  ly2_reg;
    logic                gap_reg;
    logic signed [15:0]  ylv_reg;

    logic [10:0]         base;
    logic signed [33:0]  base_s;
    logic signed [33:0]  t_s;
    logic signed [33:0]  y_full;
    logic signed [15:0]  y;
    logic                one_left;
    logic                pop;
    logic [15:0]         xl;
    logic [15:0]         xr;
    logic [15:0]         yb;
    logic [15:0]         yt;

    always_comb begin
        base     = {1'b0, cfg.pos_y} + {1'b0, cfg.plot_height};
        base_s   = 34'(base);
        t_s      = {2'b00, s3_t};
        y_full   = s3_neg ? base_s + t_s : base_s - t_s;
        y        = sat16(y_full);
        one_left = (mask_reg & (mask_reg - 4'd1)) == 4'd0;
        pop      = m_valid && m_ready;
        adv      = (mask_reg == 4'd0) || (m_ready && one_left);
        xl       = {6'd0, cfg.pos_x};
        xr       = {6'd0, cfg.pos_x} + {6'd0, cfg.plot_width};
        yb       = {6'd0, cfg.pos_y} + {6'd0, cfg.plot_height} - 16'd1;
        yt       = {6'd0, cfg.pos_y};

        if (adv) begin
            mask_next = s3_vld ? {s3_item.last && s3_item.smp_valid, s3_item.last,
                                  s3_item.last, s3_item.link} : 4'd0;
        end else if (pop) begin
            mask_next = mask_reg & (mask_reg - 4'd1);
        end else begin
            mask_next = mask_reg;
        end
    end

    always_comb begin
        priority if (mask_reg[0]) begin
            m_data = {ly2_reg, lx2_reg, ly1_reg, lx1_reg};
            m_kind = gap_reg ? KIND_GAP : KIND_DATA;
        end else if (mask_reg[1]) begin
            m_data = {yb, xr, yb, xl};
            m_kind = KIND_AXIS;
        end else if (mask_reg[2]) begin
            m_data = {yt, xr, yt, xl};
            m_kind = KIND_AXIS;
        end else begin
            m_data = {ylv_reg, xr, ylv_reg, xl};
            m_kind = KIND_LEVEL;
        end
    end

    assign m_valid = mask_reg != 4'd0;
    assign m_last  = one_left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else begin
            mask_reg <= mask_next;
            if (adv && s3_vld) begin
                lx1_reg <= prev_x_reg;
                ly1_reg <= prev_y_reg;
                lx2_reg <= s3_item.x;
                ly2_reg <= y;
                gap_reg <= s3_item.link_gap;
                ylv_reg <= y;
                if (s3_item.plot) begin
                    prev_x_reg <= s3_item.x;
                    prev_y_reg <= y;
                end
            end
        end
    end

endmodule

// File: design/plot_samples_to_segments_top.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata sample_value, tuser sample_valid
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata seg_x1..seg_y2, tuser seg_kind,
//                                              tlast run_last
// cfg       in   cfg_wr_en                     cfg_index, cfg_wdata
//
// One sample per cycle enters a four-stage path (capture, difference, multiply, map)
// when the output is not stalled and no window-index divide is running.
// A sample yields zero to four beats; the output slot sends one beat per cycle while
// m_axis_tready is high, so a frame-end sample holds the input until its beats drain.
// Each register write triggers a serial divide of the max(COUNT_BITS,16)-bit window
// index, during which s_axis_tready is low.
// Reset is synchronous on aresetn low; config registers return to their defaults.
module plot_samples_to_segments_top #(
    parameter int COUNT_BITS = ps2s_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // [31:0] sample_value
    input  logic [0:0]                         s_axis_tuser,  // [0] sample_valid
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata,  // seg_x1, seg_y1, seg_x2, seg_y2
    output logic [1:0]                         m_axis_tuser,  // [1:0] seg_kind
    output logic                               m_axis_tlast,
    input  logic                               cfg_wr_en,
    input  logic [ps2s_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2s_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ps2s_pkg::*;

    cfg_t               cfg_reg;
    logic               adv;
    logic               s1_vld;
    item_t              s1_item;
    logic signed [31:0] s1_raw;
    logic               s3_vld;
    item_t              s3_item;
    logic [31:0]        s3_t;
    logic               s3_neg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_x       <= 10'd0;
            cfg_reg.pos_y       <= 10'd0;
            cfg_reg.plot_width  <= 10'd2;
            cfg_reg.plot_height <= 10'd1;
            cfg_reg.y_min       <= 32'sd0;
            cfg_reg.y_scale     <= 32'd65536;
            cfg_reg.samples     <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POS_X:       cfg_reg.pos_x       <= cfg_wdata[9:0];
                REG_POS_Y:       cfg_reg.pos_y       <= cfg_wdata[9:0];
                REG_PLOT_WIDTH:  cfg_reg.plot_width  <= cfg_wdata[9:0];
                REG_PLOT_HEIGHT: cfg_reg.plot_height <= cfg_wdata[9:0];
                REG_Y_MIN:       cfg_reg.y_min       <= cfg_wdata;
                REG_Y_SCALE:     cfg_reg.y_scale     <= cfg_wdata;
                REG_SAMPLES:     cfg_reg.samples     <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    ps2s_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_wr_en (cfg_wr_en),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_value   (s_axis_tdata),
        .s_flag    (s_axis_tuser[0]),
        .adv       (adv),
        .s1_vld    (s1_vld),
        .s1_item   (s1_item),
        .s1_raw    (s1_raw)
    );

    ps2s_ymap u_ymap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .adv     (adv),
        .s1_vld  (s1_vld),
        .s1_item (s1_item),
        .s1_raw  (s1_raw),
        .s3_vld  (s3_vld),
        .s3_item (s3_item),
        .s3_t    (s3_t),
        .s3_neg  (s3_neg)
    );

    ps2s_seg_out u_seg_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s3_vld  (s3_vld),
        .s3_item (s3_item),
        .s3_t    (s3_t),
        .s3_neg  (s3_neg),
        .adv     (adv),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_kind  (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

endmodule
